// ===== hdl/osc_pkg.sv =====
// Shared types, constants and the character fold function of the substring counter.
package osc_pkg;

	localparam int PATTERN_MAX_DEF = 8;
	localparam int PAT_BYTES = 8;
	localparam int PAT_IDX_W = 3;
	localparam int LEN_W = 4;
	localparam int COUNT_W = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CASE_SENSITIVE = 2'd2;

	typedef struct packed {
		logic shift;
		logic clear;
		logic fold;
		logic [LEN_W-1:0] len;
		logic [PAT_BYTES-1:0][7:0] pattern;
	} osc_cell_ctrl_t;

	function automatic logic [7:0] fold_char(input logic [7:0] b, input logic fold_en);
		logic [7:0] r;
		r = b;
		if (fold_en && (b >= 8'h41) && (b <= 8'h5A)) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

// ===== hdl/overlapping_substring_counter.sv =====
// Top level of the overlapping substring counter: config registers, cell row, total, output.
// The block takes one text word per clock cycle while s_axis_tready is high and counts
// every occurrence of the pattern, overlapping ones included, at the word that carries its
// last byte. A row of PATTERN_MAX cells holds the recent bytes and compares the whole
// window in the cycle a byte arrives, so the 32-bit running total updates once per word.
// The total of a text goes into the output register, or into the one skid register while
// the output register holds a result; so the input flows while one result waits and stalls
// only while two wait. Configuration is taken at any cycle and always ready.
module overlapping_substring_counter #(
	parameter int PATTERN_MAX = osc_pkg::PATTERN_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // text_byte
	input  logic [0:0]                      s_axis_tuser,  // byte_present
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [osc_pkg::COUNT_W-1:0]     m_axis_tdata,  // match_count
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [osc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [osc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import osc_pkg::*;

	logic [CFG_DATA_W-1:0] pattern_bytes_q;
	logic [LEN_W-1:0] pattern_length_q;
	logic case_sensitive_q;
	logic [COUNT_W-1:0] total_q;

	logic in_fire;
	logic present;
	logic window_hit;
	logic [COUNT_W-1:0] total_next;
	logic buf_full;
	osc_cell_ctrl_t ctrl;

	logic [PATTERN_MAX-1:0][7:0] chain_byte;
	logic [PATTERN_MAX-1:0] chain_valid;
	logic [PATTERN_MAX-1:0] cell_hit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q <= '0;
			pattern_length_q <= '0;
			case_sensitive_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PATTERN_BYTES: pattern_bytes_q <= cfg_data;
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				REG_CASE_SENSITIVE: case_sensitive_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !buf_full;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign present = s_axis_tuser[0];

	always_comb begin
		ctrl.shift = in_fire && present;
		ctrl.clear = in_fire && s_axis_tlast;
		ctrl.fold = !case_sensitive_q;
		ctrl.len = (pattern_length_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
			: pattern_length_q;
		ctrl.pattern = pattern_bytes_q;
	end

	assign chain_byte[0] = s_axis_tdata;
	assign chain_valid[0] = 1'b1;

	generate
		for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
			if (k < PATTERN_MAX - 1) begin : g_mid
				osc_cell #(.IDX(k), .HAS_REG(1'b1)) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl),
					.din        (chain_byte[k]),
					.din_valid  (chain_valid[k]),
					.dout       (chain_byte[k+1]),
					.dout_valid (chain_valid[k+1]),
					.hit        (cell_hit[k])
				);
			end else begin : g_end
				osc_cell #(.IDX(k), .HAS_REG(1'b0)) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (ctrl),
					.din        (chain_byte[k]),
					.din_valid  (chain_valid[k]),
					.dout       (),
					.dout_valid (),
					.hit        (cell_hit[k])
				);
			end
		end
	endgenerate

	assign window_hit = &cell_hit;
	assign total_next = total_q
		+ COUNT_W'(present && window_hit && (total_q != {COUNT_W{1'b1}}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (in_fire) begin
			total_q <= s_axis_tlast ? '0 : total_next;
		end
	end

	osc_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire && s_axis_tlast),
		.push_data (total_next),
		.full      (buf_full),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_data    (m_axis_tdata)
	);

endmodule

// ===== hdl/osc_cell.sv =====
// One window cell: compares its input byte and, unless it is the last cell, holds it and passes it on.
module osc_cell #(
	parameter int IDX = 0,
	parameter bit HAS_REG = 1'b1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  osc_pkg::osc_cell_ctrl_t ctrl,
	input  logic [7:0]              din,
	input  logic                    din_valid,
	output logic [7:0]              dout,
	output logic                    dout_valid,
	output logic                    hit
);
	import osc_pkg::*;

	logic [PAT_IDX_W-1:0] pidx;
	logic active;
	logic [7:0] pat_char;

	always_comb begin
		pidx = PAT_IDX_W'(ctrl.len - LEN_W'(IDX) - LEN_W'(1));
		active = LEN_W'(IDX) < ctrl.len;
		pat_char = ctrl.pattern[pidx];
		hit = !active ||
			(din_valid && (fold_char(din, ctrl.fold) == fold_char(pat_char, ctrl.fold)));
	end

	generate
		if (HAS_REG) begin : g_reg
			logic [7:0] byte_q;
			logic valid_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_q <= 1'b0;
				end else if (ctrl.clear) begin
					valid_q <= 1'b0;
				end else if (ctrl.shift) begin
					valid_q <= din_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (ctrl.shift) begin
					byte_q <= din;
				end
			end

			assign dout = byte_q;
			assign dout_valid = valid_q;
		end else begin : g_noreg
			assign dout = '0;
			assign dout_valid = 1'b0;
		end
	endgenerate

endmodule

// ===== hdl/osc_result_buf.sv =====
// Two-entry result buffer: an output register and a skid register behind it.
module osc_result_buf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [osc_pkg::COUNT_W-1:0] push_data,
	output logic                        full,
	output logic                        m_valid,
	input  logic                        m_ready,
	output logic [osc_pkg::COUNT_W-1:0] m_data
);
	import osc_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	logic [COUNT_W-1:0] out_data_q;
	logic [COUNT_W-1:0] skid_data_q;
	logic out_free;

	assign out_free = !out_valid_q || m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign full = skid_valid_q;
	assign m_valid = out_valid_q;
	assign m_data = out_data_q;

endmodule

// ===== hdl/osc_checker.sv =====
// Port-level checker for the substring counter and its bind to the top level.
module osc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        s_axis_tlast,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [osc_pkg::COUNT_W-1:0] m_axis_tdata
);
	import osc_pkg::*;

	logic s_fire;

	assign s_fire = s_axis_tvalid && s_axis_tready;

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("Input stalled with no result waiting.");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_axis_tlast && !m_axis_tvalid) |=> m_axis_tvalid)
		else $error("End of text gave no result.");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_fire && !m_axis_tvalid) |=> !m_axis_tvalid)
		else $error("Result appeared without an end-of-text word.");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("Stalled result changed.");

endmodule

bind overlapping_substring_counter osc_checker u_osc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
